/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL of the point Jacobian block.
// Depends on nothing; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* hw/rtl/rgbdpj_pkg.sv */
// Payload types of the point Jacobian block.
// Depends on nothing; used by the top level and its users.
package rgbdpj_pkg;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic [30:0]        point_z;
        logic signed [31:0] int_grad_u;
        logic signed [31:0] int_grad_v;
        logic signed [31:0] dep_grad_u;
        logic signed [31:0] dep_grad_v;
    } t_in_item;

    typedef struct packed {
        logic               row_sel;
        logic signed [31:0] coef_tx;
        logic signed [31:0] coef_ty;
        logic signed [31:0] coef_tz;
        logic signed [31:0] coef_rx;
        logic signed [31:0] coef_ry;
        logic signed [31:0] coef_rz;
        logic               is_last;
    } t_out_item;

endpackage

/* hw/rtl/rgbd_point_jacobian_rows_core.sv */
// Top level: per-point photometric and depth Jacobian rows for se(3) motion.
// Depends on rgbdpj_pkg and assert_macros.svh.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------
//  input   | in        | i_valid / o_stall  | t_in_item, one point
//  output  | out       | o_valid / i_stall  | t_out_item, two rows a point
//
// From input transfer to the intensity row, a pipelined restoring divider,
// NDIV = (2*FRAC_BITS+2)/2 (17 at FRAC_BITS = 16), forms 1/z two quotient
// bits a stage, then six arithmetic stages and the output register follow.
// The output register sends the intensity row and then the depth row of
// each point, and takes no new point until its depth row is taken.
// Reset clears all valid bits; payload registers are not reset.
// One pipeline enable advances every stage together: a stall holds all.
`include "assert_macros.svh"

module rgbd_point_jacobian_rows_core
    import rgbdpj_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    localparam int QW   = 2 * FRAC_BITS + 1;   // quotient bits of 2^(2F)/z
    localparam int NDIV = (QW + 1) / 2;        // divider stages, two bits each
    localparam int DW   = 2 * NDIV;
    localparam int ZW   = 31;
    localparam logic signed [33:0] ONE = 34'(1) <<< FRAC_BITS;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] gu;
        logic signed [31:0] gv;
        logic signed [31:0] du;
        logic signed [31:0] dv;
    } t_pay;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat68(input logic signed [67:0] v);
        logic signed [31:0] res;
        begin
            if (v > 68'sd2147483647) res = 32'sh7fffffff;
            else if (v < -68'sd2147483648) res = 32'sh80000000;
            else res = v[31:0];
            return res;
        end
    endfunction

    // fixed point multiply: floor(a*b / 2^F), saturated
    function automatic logic signed [31:0] qmul(input logic signed [32:0] a,
                                                 input logic signed [32:0] b);
        logic signed [65:0] p;
        begin
            p = a * b;
            p = p >>> FRAC_BITS;
            return sat68(68'(p));
        end
    endfunction

    function automatic logic signed [32:0] sx(input logic signed [31:0] v);
        return {v[31], v};
    endfunction

    logic en;
    logic in_xfer;

    // ---------------- reciprocal divider stages ----------------
    logic          r_dv   [NDIV];
    logic [ZW-1:0] r_rem  [NDIV];
    logic [DW-1:0] r_q    [NDIV];
    logic [ZW-1:0] r_z    [NDIV];
    t_pay          r_dp   [NDIV];
    logic [ZW-1:0] n_rem  [NDIV];
    logic [DW-1:0] n_q    [NDIV];

    always_comb begin : p_div
        logic [ZW-1:0] rem;
        logic [DW-1:0] q;
        logic [ZW-1:0] z;
        logic [ZW:0]   t;
        logic          bitv;
        for (int k = 0; k < NDIV; k++) begin
            if (k == 0) begin
                rem = '0;
                q   = '0;
                z   = i_data.point_z;
            end else begin
                rem = r_rem[k-1];
                q   = r_q[k-1];
                z   = r_z[k-1];
            end
            for (int s = 0; s < 2; s++) begin
                // the dividend is one set bit at position 2F
                bitv = ((DW - 1 - (2 * k + s)) == 2 * FRAC_BITS);
                t    = {rem, bitv};
                if (t >= {1'b0, z}) begin
                    rem = ZW'(t - {1'b0, z});
                    q   = {q[DW-2:0], 1'b1};
                end else begin
                    rem = t[ZW-1:0];
                    q   = {q[DW-2:0], 1'b0};
                end
            end
            n_rem[k] = rem;
            n_q[k]   = q;
        end
    end

    t_pay in_pay;
    assign in_pay = '{x: i_data.point_x, y: i_data.point_y,
                      gu: i_data.int_grad_u, gv: i_data.int_grad_v,
                      du: i_data.dep_grad_u, dv: i_data.dep_grad_v};

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NDIV; k++) begin
                r_rem[k] <= n_rem[k];
                r_q[k]   <= n_q[k];
                if (k == 0) begin
                    r_z[k]  <= i_data.point_z;
                    r_dp[k] <= in_pay;
                end else begin
                    r_z[k]  <= r_z[k-1];
                    r_dp[k] <= r_dp[k-1];
                end
            end
        end
    end

    // saturate the quotient to the Q range
    logic signed [31:0] recip;
    assign recip = (64'(r_q[NDIV-1]) > 64'h7fffffff) ? 32'sh7fffffff
                                                     : 32'(r_q[NDIV-1]);

    // ---------------- arithmetic stages ----------------
    logic r_v1, r_v2, r_v3, r_v4, r_vp, r_vs;
    t_pay r_p1, r_p2, r_p3, r_p4;

    // stage 1: r, r^2, x*r, -y*r
    logic signed [31:0] r_r1, r_r2, r_xr1, r_nyr1;
    // stage 2: a, c
    logic signed [31:0] r_rb2, r_xr2, r_nyr2, r_a2, r_c2;
    // stage 3: b, a*x, c*y
    logic signed [31:0] r_rb3, r_xr3, r_nyr3, r_a3, r_c3, r_b3, r_ax3, r_cy3;
    // stage 4: Jacobian rows
    logic signed [31:0] r_j0 [6];
    logic signed [31:0] r_j1 [6];
    // product stage
    logic signed [31:0] r_pi0 [6];
    logic signed [31:0] r_pi1 [6];
    logic signed [31:0] r_pd0 [6];
    logic signed [31:0] r_pd1 [6];
    logic signed [32:0] r_jz  [6];
    // sum stage
    t_out_item r_s0, r_s1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1   <= r_dp[NDIV-1];
            r_r1   <= recip;
            r_r2   <= qmul(sx(recip), sx(recip));
            r_xr1  <= qmul(sx(r_dp[NDIV-1].x), sx(recip));
            r_nyr1 <= qmul(-sx(r_dp[NDIV-1].y), sx(recip));

            r_p2   <= r_p1;
            r_rb2  <= r_r1;
            r_xr2  <= r_xr1;
            r_nyr2 <= r_nyr1;
            r_a2   <= qmul(-sx(r_p1.x), sx(r_r2));
            r_c2   <= qmul(-sx(r_p1.y), sx(r_r2));

            r_p3   <= r_p2;
            r_rb3  <= r_rb2;
            r_xr3  <= r_xr2;
            r_nyr3 <= r_nyr2;
            r_a3   <= r_a2;
            r_c3   <= r_c2;
            r_b3   <= qmul(sx(r_a2), sx(r_p2.y));
            r_ax3  <= qmul(sx(r_a2), sx(r_p2.x));
            r_cy3  <= qmul(sx(r_c2), sx(r_p2.y));

            r_p4    <= r_p3;
            r_j0[0] <= r_rb3;
            r_j0[1] <= '0;
            r_j0[2] <= r_a3;
            r_j0[3] <= r_b3;
            r_j0[4] <= sat68(68'(ONE) - 68'(r_ax3));
            r_j0[5] <= r_nyr3;
            r_j1[0] <= '0;
            r_j1[1] <= r_rb3;
            r_j1[2] <= r_c3;
            r_j1[3] <= sat68(68'(r_cy3) - 68'(ONE));
            r_j1[4] <= sat68(-68'(r_b3));
            r_j1[5] <= r_xr3;

            for (int k = 0; k < 6; k++) begin
                r_pi0[k] <= qmul(sx(r_p4.gu), sx(r_j0[k]));
                r_pi1[k] <= qmul(sx(r_p4.gv), sx(r_j1[k]));
                r_pd0[k] <= qmul(sx(r_p4.du), sx(r_j0[k]));
                r_pd1[k] <= qmul(sx(r_p4.dv), sx(r_j1[k]));
            end
            // third transform row [0, 0, 1, y, -x, 0]
            r_jz[0] <= '0;
            r_jz[1] <= '0;
            r_jz[2] <= 33'(ONE);
            r_jz[3] <= sx(r_p4.y);
            r_jz[4] <= -sx(r_p4.x);
            r_jz[5] <= '0;

            r_s0.row_sel <= 1'b0;
            r_s0.is_last <= 1'b0;
            r_s0.coef_tx <= sat68(68'(r_pi0[0]) + 68'(r_pi1[0]));
            r_s0.coef_ty <= sat68(68'(r_pi0[1]) + 68'(r_pi1[1]));
            r_s0.coef_tz <= sat68(68'(r_pi0[2]) + 68'(r_pi1[2]));
            r_s0.coef_rx <= sat68(68'(r_pi0[3]) + 68'(r_pi1[3]));
            r_s0.coef_ry <= sat68(68'(r_pi0[4]) + 68'(r_pi1[4]));
            r_s0.coef_rz <= sat68(68'(r_pi0[5]) + 68'(r_pi1[5]));
            r_s1.row_sel <= 1'b1;
            r_s1.is_last <= 1'b1;
            r_s1.coef_tx <= sat68(68'(r_pd0[0]) + 68'(r_pd1[0]) - 68'(r_jz[0]));
            r_s1.coef_ty <= sat68(68'(r_pd0[1]) + 68'(r_pd1[1]) - 68'(r_jz[1]));
            r_s1.coef_tz <= sat68(68'(r_pd0[2]) + 68'(r_pd1[2]) - 68'(r_jz[2]));
            r_s1.coef_rx <= sat68(68'(r_pd0[3]) + 68'(r_pd1[3]) - 68'(r_jz[3]));
            r_s1.coef_ry <= sat68(68'(r_pd0[4]) + 68'(r_pd1[4]) - 68'(r_jz[4]));
            r_s1.coef_rz <= sat68(68'(r_pd0[5]) + 68'(r_pd1[5]) - 68'(r_jz[5]));
        end
    end

    // ---------------- output register: two rows per point ----------------
    logic      r_ov;
    logic      r_row;
    t_out_item r_o0, r_o1;

    // advance when the output register is empty or sends its last row
    assign en      = !r_ov || (!i_stall && r_row);
    assign o_stall = !en;
    assign in_xfer = i_valid && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NDIV; k++) r_dv[k] <= 1'b0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
            r_vp  <= 1'b0;
            r_vs  <= 1'b0;
            r_ov  <= 1'b0;
            r_row <= 1'b0;
        end else if (en) begin
            r_dv[0] <= in_xfer;
            for (int k = 1; k < NDIV; k++) r_dv[k] <= r_dv[k-1];
            r_v1  <= r_dv[NDIV-1];
            r_v2  <= r_v1;
            r_v3  <= r_v2;
            r_v4  <= r_v3;
            r_vp  <= r_v4;
            r_vs  <= r_vp;
            r_ov  <= r_vs;
            r_row <= 1'b0;
        end else if (!i_stall) begin
            // intensity row taken: advance to the depth row
            r_row <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o0 <= r_s0;
            r_o1 <= r_s1;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_row ? r_o1 : r_o0;

    // ---------------- checks ----------------
    `ASSERT_IMPLIES(a_depth_follows, i_clk, i_rst_n, o_valid && !i_stall && !r_row, o_valid && r_row, "depth row must follow intensity row")
    `ASSERT_ALWAYS(a_stall_only_full, i_clk, i_rst_n, !o_stall || r_ov, "input stalled while output register empty")
    `ASSERT_IMPLIES(a_hold_rows, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(r_row), "row pointer moved under stall")

endmodule
